/* rtl/core/coordinate_message_parser_assert.svh */
// assertion macros shared by the parser modules
`ifndef COORDINATE_MESSAGE_PARSER_ASSERT_SVH
`define COORDINATE_MESSAGE_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cmp_pkg.sv */
package cmp_pkg;

  // fixed field widths
  localparam int FRAC_DIGITS = 6;
  localparam int FC_W   = 3;
  localparam int MAG_W  = 28;
  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int ST_W   = 3;
  localparam int POW_W  = 24;
  localparam int PROD_W = MAG_W + POW_W;
  localparam int ACC_W  = 32;
  localparam int OUT_W  = ST_W + LAT_W + LON_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // byte queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SEP     = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_PREFIX = 3'd2;
  localparam logic [ST_W-1:0] ST_LAT_BAD    = 3'd3;
  localparam logic [ST_W-1:0] ST_LON_BAD    = 3'd4;

  // characters
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int LAT_PFX_LEN = 4;
  localparam int LON_PFX_LEN = 5;
  // "lat " and "long "
  localparam logic [7:0] LAT_PFX [LAT_PFX_LEN] = '{8'h6c, 8'h61, 8'h74, 8'h20};
  localparam logic [7:0] LON_PFX [LON_PFX_LEN] = '{8'h6c, 8'h6f, 8'h6e, 8'h67, 8'h20};

  function automatic logic [POW_W-1:0] pow10(input logic [FC_W-1:0] n);
    logic [POW_W-1:0] r;
    case (n)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

  localparam logic [POW_W-1:0]  SCALE     = pow10(FC_W'(FRAC_DIGITS));
  localparam logic [ACC_W-1:0]  NUM_CAP   = ACC_W'(180) * ACC_W'(SCALE);
  localparam logic [PROD_W-1:0] LAT_LIMIT = PROD_W'(90) * PROD_W'(SCALE);
  localparam logic [PROD_W-1:0] LON_LIMIT = PROD_W'(180) * PROD_W'(SCALE);

  typedef enum logic [2:0] {
    CL_DIGIT, CL_DOT, CL_MINUS, CL_SEMI, CL_OTHER
  } tok_class_t;

  typedef struct packed {
    logic [7:0] byte_val;
    tok_class_t cls;
    logic       last;
  } tok_t;

  typedef enum logic [2:0] {
    PH_LAT_PREFIX, PH_LAT_NUM, PH_LON_PREFIX, PH_LON_NUM, PH_WAIT_SEP, PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    FIN_NO_SEP, FIN_BAD_PREFIX, FIN_NUMBERS
  } fin_kind_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [FC_W-1:0]  fc;
    logic             neg;
    logic             ovf;
  } num_t;

  typedef struct packed {
    fin_kind_t kind;
    logic      check_lat;
    num_t      lat;
    num_t      lon;
  } fin_req_t;

endpackage

/* rtl/core/cmp_front.sv */
module cmp_front
  import cmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output tok_t       tok
);

  tok_class_t cls;

  always_comb begin
    if (in_data >= CH_ZERO && in_data <= CH_NINE) begin
      cls = CL_DIGIT;
    end else if (in_data == CH_DOT) begin
      cls = CL_DOT;
    end else if (in_data == CH_MINUS) begin
      cls = CL_MINUS;
    end else if (in_data == CH_SEMI) begin
      cls = CL_SEMI;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign in_ready = !q_full && !rst;
  assign push     = in_valid && in_ready;

  assign tok.byte_val = in_data;
  assign tok.cls      = cls;
  assign tok.last     = in_last;

  // clk is only used by the checker below
  `include "coordinate_message_parser_assert.svh"

  `CMP_ASSERT_NOW(a_front_no_push_full, push, !q_full, "push while queue full")
  `CMP_ASSERT_NOW(a_front_digit_class, push && cls == CL_DIGIT, in_data[7:4] == 4'h3, "bad digit class")
  `CMP_ASSERT_NOW(a_front_semi_class, push && in_data == CH_SEMI, cls == CL_SEMI, "separator misclassified")

endmodule

/* rtl/core/cmp_queue.sv */
module cmp_queue
  import cmp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t wr_tok,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output tok_t rd_tok
);

  tok_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign rd_tok    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `include "coordinate_message_parser_assert.svh"

  `CMP_ASSERT_NOW(a_q_no_pop_empty, pop, count != '0, "pop from empty queue")
  `CMP_ASSERT_NOW(a_q_cnt_max, 1'b1, count <= QCNT_W'(QDEPTH), "queue count over depth")
  `CMP_ASSERT_NEXT(a_q_cnt_up, push && !pop, count == $past(count) + 1'b1, "count missed push")
  `CMP_ASSERT_NEXT(a_q_cnt_dn, pop && !push, count == $past(count) - 1'b1, "count missed pop")

endmodule

/* rtl/core/cmp_back.sv */
module cmp_back
  import cmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     tok_valid,
  input  tok_t     tok,
  input  logic     req_ready,
  output logic     tok_pop,
  output logic     req_valid,
  output fin_req_t req
);

  phase_t           phase, phase_next;
  logic [2:0]       prefix_pos, prefix_pos_next;
  num_t             num, num_next;
  logic             point_seen, point_seen_next;
  logic             first_of_number, first_next;
  num_t             lat, lat_next;
  logic             lat_done, lat_done_next;

  // number state after this byte
  num_t             nb;
  logic             nb_point, take;
  logic [ACC_W-1:0] acc;

  always_comb begin
    nb       = num;
    nb_point = point_seen;
    take     = 1'b1;
    acc      = {{(ACC_W-MAG_W){1'b0}}, num.mag};
    case (tok.cls)
      CL_MINUS: begin
        if (first_of_number) begin
          nb.neg = 1'b1;
        end
      end
      CL_DIGIT: begin
        if (point_seen) begin
          if (num.fc < FC_W'(FRAC_DIGITS)) begin
            nb.fc = num.fc + 1'b1;
          end else begin
            take = 1'b0;
          end
        end
        acc = (acc << 3) + (acc << 1) + ACC_W'(tok.byte_val[3:0]);
        if (take && !num.ovf) begin
          nb.mag = acc[MAG_W-1:0];
          if (acc > NUM_CAP) begin
            nb.ovf = 1'b1;
          end
        end
      end
      CL_DOT:  nb_point = 1'b1;
      default: nb.ovf = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    num_next        = num;
    point_seen_next = point_seen;
    first_next      = first_of_number;
    lat_next        = lat;
    lat_done_next   = lat_done;
    case (phase)
      PH_LAT_PREFIX: begin
        if (tok.byte_val == LAT_PFX[prefix_pos[1:0]]) begin
          if (prefix_pos == 3'(LAT_PFX_LEN - 1)) begin
            phase_next      = PH_LAT_NUM;
            prefix_pos_next = '0;
            num_next        = '0;
            point_seen_next = 1'b0;
            first_next      = 1'b1;
          end else begin
            prefix_pos_next = prefix_pos + 1'b1;
          end
        end else begin
          phase_next = (tok.cls == CL_SEMI) ? PH_DRAIN : PH_WAIT_SEP;
        end
      end
      PH_LAT_NUM: begin
        if (tok.cls == CL_SEMI) begin
          lat_next        = num;
          lat_done_next   = 1'b1;
          phase_next      = PH_LON_PREFIX;
          prefix_pos_next = '0;
        end else begin
          num_next        = nb;
          point_seen_next = nb_point;
          first_next      = 1'b0;
        end
      end
      PH_LON_PREFIX: begin
        if (tok.byte_val == LON_PFX[prefix_pos]) begin
          if (prefix_pos == 3'(LON_PFX_LEN - 1)) begin
            phase_next      = PH_LON_NUM;
            prefix_pos_next = '0;
            num_next        = '0;
            point_seen_next = 1'b0;
            first_next      = 1'b1;
          end else begin
            prefix_pos_next = prefix_pos + 1'b1;
          end
        end else begin
          phase_next = PH_DRAIN;
        end
      end
      PH_LON_NUM: begin
        num_next        = nb;
        point_seen_next = nb_point;
        first_next      = 1'b0;
      end
      PH_WAIT_SEP: begin
        if (tok.cls == CL_SEMI) begin
          phase_next = PH_DRAIN;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // outputs
  always_comb begin
    tok_pop       = tok_valid && (!tok.last || req_ready);
    req_valid     = tok_pop && tok.last;
    req.check_lat = lat_done_next;
    req.lat       = lat_next;
    req.lon       = num_next;
    case (phase_next)
      PH_LON_PREFIX, PH_DRAIN: req.kind = FIN_BAD_PREFIX;
      PH_LON_NUM:              req.kind = FIN_NUMBERS;
      default:                 req.kind = FIN_NO_SEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (tok_pop && tok.last)) begin
      phase           <= PH_LAT_PREFIX;
      prefix_pos      <= '0;
      num             <= '0;
      point_seen      <= 1'b0;
      first_of_number <= 1'b1;
      lat             <= '0;
      lat_done        <= 1'b0;
    end else if (tok_pop) begin
      phase           <= phase_next;
      prefix_pos      <= prefix_pos_next;
      num             <= num_next;
      point_seen      <= point_seen_next;
      first_of_number <= first_next;
      lat             <= lat_next;
      lat_done        <= lat_done_next;
    end
  end

  `include "coordinate_message_parser_assert.svh"

  `CMP_ASSERT_NOW(a_back_req_ready, req_valid, req_ready, "request dropped")
  `CMP_ASSERT_NEXT(a_back_restart, tok_pop && tok.last, phase == PH_LAT_PREFIX && !lat_done, "no restart after message")
  `CMP_ASSERT_NOW(a_back_lat_done, lat_done, phase == PH_LON_PREFIX || phase == PH_LON_NUM || phase == PH_DRAIN, "latitude latched in wrong phase")

endmodule

/* rtl/core/cmp_finish.sv */
module cmp_finish
  import cmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  fin_req_t         req,
  output logic             req_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  status,
  output logic [LAT_W-1:0] lat_micro,
  output logic [LON_W-1:0] lon_micro
);

  // stage a: captured request
  logic              a_valid;
  fin_req_t          a_req;
  // stage b: scaled magnitudes
  logic              b_valid;
  fin_kind_t         b_kind;
  logic              b_check_lat;
  logic [PROD_W-1:0] b_lat_prod, b_lon_prod;
  logic              b_lat_neg, b_lon_neg, b_lat_ovf, b_lon_ovf;

  logic              a_ready, b_ready, c_ready;
  logic              lat_bad, lon_bad;
  logic [ST_W-1:0]   st_calc;

  assign c_ready   = !out_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= req_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req_valid) begin
      a_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_kind      <= a_req.kind;
      b_check_lat <= a_req.check_lat;
      b_lat_prod  <= PROD_W'(a_req.lat.mag)
                   * PROD_W'(pow10(FC_W'(FRAC_DIGITS) - a_req.lat.fc));
      b_lon_prod  <= PROD_W'(a_req.lon.mag)
                   * PROD_W'(pow10(FC_W'(FRAC_DIGITS) - a_req.lon.fc));
      b_lat_neg   <= a_req.lat.neg;
      b_lon_neg   <= a_req.lon.neg;
      b_lat_ovf   <= a_req.lat.ovf;
      b_lon_ovf   <= a_req.lon.ovf;
    end
  end

  // a bad latitude outranks any later error
  always_comb begin
    lat_bad = b_lat_ovf || (b_lat_prod > LAT_LIMIT);
    lon_bad = b_lon_ovf || (b_lon_prod > LON_LIMIT);
    if (b_kind == FIN_NO_SEP) begin
      st_calc = ST_NO_SEP;
    end else if (b_check_lat && lat_bad) begin
      st_calc = ST_LAT_BAD;
    end else if (b_kind == FIN_BAD_PREFIX) begin
      st_calc = ST_BAD_PREFIX;
    end else if (lon_bad) begin
      st_calc = ST_LON_BAD;
    end else begin
      st_calc = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      status <= st_calc;
      if (st_calc == ST_OK) begin
        lat_micro <= b_lat_neg ? LAT_W'(0) - b_lat_prod[LAT_W-1:0] : b_lat_prod[LAT_W-1:0];
        lon_micro <= b_lon_neg ? LON_W'(0) - b_lon_prod[LON_W-1:0] : b_lon_prod[LON_W-1:0];
      end else begin
        lat_micro <= '0;
        lon_micro <= '0;
      end
    end
  end

  `include "coordinate_message_parser_assert.svh"

  `CMP_ASSERT_NEXT(a_fin_hold_b, b_valid && !c_ready, b_valid, "stage b lost under stall")
  `CMP_ASSERT_NOW(a_fin_zero_err, out_valid && status != ST_OK, lat_micro == '0 && lon_micro == '0, "payload not cleared on error")
  `CMP_ASSERT_NOW(a_fin_status_range, out_valid, status <= ST_LON_BAD, "status code out of range")

endmodule

/* rtl/core/coordinate_message_parser.sv */
// coordinate message parser: takes "lat <num>;long <num>" one ASCII byte per
// request on the s_axis side, tlast on the final byte, and returns one result
// per message on the m_axis side: status (0 ok, 1 no separator, 2 bad prefix,
// 3 latitude invalid, 4 longitude invalid) plus latitude and longitude in
// millionths of a degree, both zero unless status is ok. bytes are taken one
// per clock, back to back, as long as the 4-entry byte queue has room; the
// per-byte parser step (one shift-add accumulate and compare) sets that rate.
// after the last byte is taken, the parser pops it from the byte queue and
// the finish pipeline captures its request on that same edge; the scaling
// multiply and then the range check into the output register are each
// registered stages. the output register lets the next message stream in
// while a result waits for m_axis_tready.
module coordinate_message_parser
  import cmp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // byte side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] byte_in
  input  logic                   s_axis_tlast,   // is_last
  // result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_BYTES_W-1:0] m_axis_tdata    // [2:0] status, [30:3] lat_micro,
                                                 // [59:31] lon_micro, rest zero
);

  // front to queue
  logic     q_push, q_full, q_not_empty, q_pop;
  tok_t     q_wr_tok, q_rd_tok;
  // back to finish request
  logic     req_valid, req_ready;
  fin_req_t req;

  logic [ST_W-1:0]  status;
  logic [LAT_W-1:0] lat_micro;
  logic [LON_W-1:0] lon_micro;

  // classify each byte and push it into the queue
  cmp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (q_push),
    .tok      (q_wr_tok)
  );

  // short queue so front and parser stall on their own
  cmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_tok    (q_wr_tok),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_tok    (q_rd_tok)
  );

  // prefix matching and number accumulation, one request per message end
  cmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_not_empty),
    .tok       (q_rd_tok),
    .req_ready (req_ready),
    .tok_pop   (q_pop),
    .req_valid (req_valid),
    .req       (req)
  );

  // scale, range check, sign and output register
  cmp_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .lat_micro (lat_micro),
    .lon_micro (lon_micro)
  );

  // pack fields from the lowest bit up, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_BYTES_W-OUT_W){1'b0}}, lon_micro, lat_micro, status};

endmodule
